/* rtl/lhlt_pkg.sv */
package lhlt_pkg;

    // transaction codes
    typedef enum logic {
        CMD_OBSERVE = 1'b0,
        CMD_READ    = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_AGED      = 3'd2,
        ST_UNCHANGED = 3'd3,
        ST_NOT_LAN   = 3'd4,
        ST_ZERO_MAC  = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_AGEOUT = 2'd0,
        REG_IGN_LO = 2'd1,
        REG_IGN_HI = 2'd2
    } reg_idx_t;

    localparam logic [15:0] AGEOUT_RST = 16'd300;
    localparam logic [31:0] IGN_LO_RST = 32'hC0A8_0178;
    localparam logic [31:0] IGN_HI_RST = 32'hC0A8_0181;

    typedef struct packed {
        logic [15:0] ageout;
        logic [31:0] ign_lo;
        logic [31:0] ign_hi;
    } cfg_t;

    // one table entry as held in the ram
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] idle;
        logic [31:0] stamp;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

/* rtl/lhlt_if.sv */
interface lhlt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface lhlt_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [47:0] host_mac;
    logic [31:0] host_ip;
    logic [15:0] idle_seconds;
    logic        from_lan;
    logic [31:0] now_seconds;
    logic [4:0]  read_index;

    modport source (output valid, output command, output host_mac, output host_ip,
                    output idle_seconds, output from_lan, output now_seconds,
                    output read_index, input ready);
    modport sink   (input valid, input command, input host_mac, input host_ip,
                    input idle_seconds, input from_lan, input now_seconds,
                    input read_index, output ready);
endinterface

interface lhlt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  entry_index;
    logic        entry_valid;
    logic [47:0] entry_mac;
    logic [31:0] entry_ip;
    logic [15:0] entry_idle;
    logic [31:0] online_seconds;
    logic        was_new;

    modport source (output valid, output status, output entry_index, output entry_valid,
                    output entry_mac, output entry_ip, output entry_idle,
                    output online_seconds, output was_new, input ready);
    modport sink   (input valid, input status, input entry_index, input entry_valid,
                    input entry_mac, input entry_ip, input entry_idle,
                    input online_seconds, input was_new, output ready);
endinterface

/* rtl/lhlt_ram.sv */
module lhlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/lhlt_cfg_regs.sv */
module lhlt_cfg_regs import lhlt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    lhlt_cfg_if.sink   cfg,
    output cfg_t       cfg_q
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ageout <= AGEOUT_RST;
            cfg_reg.ign_lo <= IGN_LO_RST;
            cfg_reg.ign_hi <= IGN_HI_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (reg_idx_t'(cfg.index))
                REG_AGEOUT: cfg_reg.ageout <= cfg.data[15:0];
                REG_IGN_LO: cfg_reg.ign_lo <= cfg.data;
                REG_IGN_HI: cfg_reg.ign_hi <= cfg.data;
                default:    ; // unused index, write dropped
            endcase
        end
    end

endmodule

/* rtl/lan_host_learning_table.sv */
// LAN host learning table: up to ENTRIES hosts keyed by 48-bit MAC, held in one
// single-port-read synchronous ram (mac, ip, idle, start stamp) with valid, new and
// written bits in flip-flops. An observe transaction scans the ram one entry per cycle
// (the compare works on the read issued in the cycle before) and stops at the first MAC match.
// A read fetches and loads its slot; an observe that matches, or that allocates a free
// slot when nothing matches, fetches and loads that slot. A full table ends the scan in
// the finish step without a fetch; a rejected observe (not LAN, zero MAC) or an out of
// range read goes to the finish step straight from idle.
// The result shows on rsp as the block turns ready for the next item. The scan
// through the ram sets the rate: one item is in work at a time, and req.ready is high
// only while the block is idle. The result sits in an output register, so the next item
// is taken while a result still waits on rsp; that item then holds in its finish step
// until rsp is free. Entries never written read as zero through the written bits, so no
// clearing pass is needed after reset. Configuration writes are always accepted and
// take effect at once.
module lan_host_learning_table import lhlt_pkg::*; #(
    parameter int ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lhlt_cfg_if.sink    cfg,
    lhlt_req_if.sink    req,
    lhlt_rsp_if.source  rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_FETCH  = 5'b00100,
        S_LOAD   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    // what the finish step does with the transaction
    typedef enum logic [1:0] {
        MODE_OBSERVE = 2'd0,
        MODE_READ    = 2'd1,
        MODE_EMPTY   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  entry_index;
        logic        entry_valid;
        logic [47:0] entry_mac;
        logic [31:0] entry_ip;
        logic [15:0] entry_idle;
        logic [31:0] online_seconds;
        logic        was_new;
    } rsp_t;

    cfg_t cfg_q;

    // control state
    state_t             state_reg, state_next;
    mode_t              mode_reg;
    status_t            status_reg;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               have_inv_reg, have_empty_reg;
    logic [IDX_W-1:0]   inv_idx_reg, empty_idx_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               alloc_reg;
    logic [ENTRIES-1:0] valid_reg, new_reg, written_reg;
    logic               rd_written_reg;
    logic               rsp_vld_reg;

    // payload held for the item in work
    logic [47:0] mac_reg;
    logic [31:0] ip_reg;
    logic [15:0] idle_reg;
    logic [31:0] now_reg;
    logic [4:0]  empty_index_reg;
    rec_t        rec_reg;
    rsp_t        rsp_reg;

    // ram ports
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    rec_t             rd_rec;

    // finish step
    logic    out_free, fin_commit, wr_req;
    logic    slot_valid, slot_new, in_ignore, fresh;
    logic    post_valid, post_new;
    rec_t    post_rec;
    status_t res_status;
    rsp_t    result;

    lhlt_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    lhlt_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (post_rec),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);

    // ram reads happen only in scan and fetch, writes only in finish, so the same
    // entry is never read and written in one cycle
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = slot_reg;
        case (state_reg)
            S_SCAN:
            begin
                ram_re    = (scan_cnt_reg < CNT_W'(ENTRIES));
                ram_raddr = scan_cnt_reg[IDX_W-1:0];
            end
            S_FETCH: ram_re = 1'b1;
            default: ;
        endcase
    end

    // never-written entries read as all zero
    assign rd_rec = rd_written_reg ? rec_t'(ram_rdata) : '0;

    assign out_free   = !rsp_vld_reg || rsp.ready;
    assign fin_commit = (state_reg == S_FINISH) && out_free;
    assign ram_we     = fin_commit && wr_req;

    // read-modify-write of the chosen slot and the result it gives
    always_comb
    begin
        slot_valid = valid_reg[slot_reg];
        slot_new   = new_reg[slot_reg];
        in_ignore  = (ip_reg >= cfg_q.ign_lo) && (ip_reg <= cfg_q.ign_hi);
        fresh      = (idle_reg < cfg_q.ageout);
        post_rec   = rec_reg;
        post_valid = slot_valid;
        post_new   = slot_new;
        wr_req     = 1'b0;
        res_status = ST_UNCHANGED;
        case (mode_reg)
            MODE_OBSERVE:
            begin
                post_new = slot_new || alloc_reg;
                if (fresh)
                begin
                    if (slot_valid && in_ignore)
                    begin
                        res_status = ST_IGNORED;
                    end
                    else
                    begin
                        post_rec.mac   = mac_reg;
                        post_rec.ip    = ip_reg;
                        post_rec.idle  = idle_reg;
                        // start stamp only on a fresh slot
                        post_rec.stamp = slot_valid ? rec_reg.stamp : now_reg;
                        post_valid     = 1'b1;
                        wr_req         = 1'b1;
                        res_status     = ST_UPDATED;
                    end
                end
                else if (slot_valid)
                begin
                    // aged out: keep mac, ip and stamp
                    post_rec.idle = '0;
                    post_valid    = 1'b0;
                    wr_req        = 1'b1;
                    res_status    = ST_AGED;
                end
            end
            MODE_READ: post_new = 1'b0;
            default:   ;
        endcase

        if (mode_reg == MODE_EMPTY)
        begin
            result             = '0;
            result.status      = status_reg;
            result.entry_index = empty_index_reg;
        end
        else
        begin
            result.status         = res_status;
            result.entry_index    = 5'(slot_reg);
            result.entry_valid    = post_valid;
            result.entry_mac      = post_rec.mac;
            result.entry_ip       = post_rec.ip;
            result.entry_idle     = post_rec.idle;
            result.online_seconds = post_valid ? (now_reg - post_rec.stamp) : '0;
            // a read reports the flag before it clears it
            result.was_new        = (mode_reg == MODE_READ) ? slot_new : post_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_EMPTY;
            status_reg     <= ST_UNCHANGED;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            have_inv_reg   <= 1'b0;
            have_empty_reg <= 1'b0;
            inv_idx_reg    <= '0;
            empty_idx_reg  <= '0;
            slot_reg       <= '0;
            alloc_reg      <= 1'b0;
            valid_reg      <= '0;
            new_reg        <= '0;
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            rsp_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_re)
            begin
                rd_written_reg <= written_reg[ram_raddr];
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        scan_cnt_reg   <= '0;
                        cmp_vld_reg    <= 1'b0;
                        have_inv_reg   <= 1'b0;
                        have_empty_reg <= 1'b0;
                        alloc_reg      <= 1'b0;
                        if (cmd_t'(req.command) == CMD_READ)
                        begin
                            if (9'(req.read_index) < 9'(ENTRIES))
                            begin
                                mode_reg <= MODE_READ;
                                slot_reg <= IDX_W'(req.read_index);
                            end
                            else
                            begin
                                mode_reg   <= MODE_EMPTY;
                                status_reg <= ST_UNCHANGED;
                            end
                        end
                        else if (!req.from_lan)
                        begin
                            mode_reg   <= MODE_EMPTY;
                            status_reg <= ST_NOT_LAN;
                        end
                        else if (req.host_mac == '0)
                        begin
                            mode_reg   <= MODE_EMPTY;
                            status_reg <= ST_ZERO_MAC;
                        end
                        else
                        begin
                            mode_reg <= MODE_OBSERVE;
                        end
                    end
                end
                S_SCAN:
                begin
                    // issue side: one address per cycle
                    cmp_vld_reg <= ram_re;
                    cmp_idx_reg <= ram_raddr;
                    if (ram_re)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    end
                    // compare side: data of the address issued last cycle
                    if (cmp_vld_reg)
                    begin
                        if (!valid_reg[cmp_idx_reg])
                        begin
                            if (!have_inv_reg)
                            begin
                                have_inv_reg <= 1'b1;
                                inv_idx_reg  <= cmp_idx_reg;
                            end
                            if (rd_rec.mac == '0 && !have_empty_reg)
                            begin
                                have_empty_reg <= 1'b1;
                                empty_idx_reg  <= cmp_idx_reg;
                            end
                        end
                        if (rd_rec.mac == mac_reg)
                        begin
                            slot_reg <= cmp_idx_reg;
                        end
                    end
                    else if (!ram_re)
                    begin
                        // scan over with no match
                        if (!have_inv_reg)
                        begin
                            mode_reg   <= MODE_EMPTY;
                            status_reg <= ST_FULL;
                        end
                        else
                        begin
                            alloc_reg <= 1'b1;
                            slot_reg  <= have_empty_reg ? empty_idx_reg : inv_idx_reg;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (fin_commit && mode_reg != MODE_EMPTY)
                    begin
                        valid_reg[slot_reg] <= post_valid;
                        new_reg[slot_reg]   <= post_new;
                        if (wr_req)
                        begin
                            written_reg[slot_reg] <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            if (fin_commit)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mac_reg         <= req.host_mac;
            ip_reg          <= req.host_ip;
            idle_reg        <= req.idle_seconds;
            now_reg         <= req.now_seconds;
            empty_index_reg <= (cmd_t'(req.command) == CMD_READ) ? req.read_index : 5'd0;
        end
        if (state_reg == S_LOAD)
        begin
            rec_reg <= rd_rec;
        end
        if (fin_commit)
        begin
            rsp_reg <= result;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    if (cmd_t'(req.command) == CMD_READ)
                    begin
                        state_next = (9'(req.read_index) < 9'(ENTRIES)) ? S_FETCH : S_FINISH;
                    end
                    else if (!req.from_lan || req.host_mac == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (cmp_vld_reg && rd_rec.mac == mac_reg)
                begin
                    state_next = S_FETCH;
                end
                else if (!cmp_vld_reg && !ram_re)
                begin
                    state_next = have_inv_reg ? S_FETCH : S_FINISH;
                end
            end
            S_FETCH:  state_next = S_LOAD;
            S_LOAD:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (fin_commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.status         = rsp_reg.status;
    assign rsp.entry_index    = rsp_reg.entry_index;
    assign rsp.entry_valid    = rsp_reg.entry_valid;
    assign rsp.entry_mac      = rsp_reg.entry_mac;
    assign rsp.entry_ip       = rsp_reg.entry_ip;
    assign rsp.entry_idle     = rsp_reg.entry_idle;
    assign rsp.online_seconds = rsp_reg.online_seconds;
    assign rsp.was_new        = rsp_reg.was_new;

    // ram writes only come out of the finish step
    a_write_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_FINISH)
        else $error("ram write outside finish step");

    // scan counter never runs past the table
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= CNT_W'(ENTRIES))
        else $error("scan counter past table end");

    // a compare slot is only filled by a scan read
    a_cmp_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmp_vld_reg) |-> $past(state_reg == S_SCAN))
        else $error("compare data without scan read");

    // a new result only appears after a finish step
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_vld_reg) |-> $past(state_reg == S_FINISH))
        else $error("result without finish step");

    // an updated observe leaves the slot valid
    a_update_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fin_commit && mode_reg == MODE_OBSERVE && res_status == ST_UPDATED
            |=> valid_reg[$past(slot_reg)])
        else $error("updated slot not valid");

endmodule
